@@ design/wcp_pkg.sv @@
package wcp_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_COLUMNS = 4096;
	localparam int REGION_BITS = 24;
	localparam int NCOL_BITS   = 13;
	localparam int INDEX_BITS  = 12;
	localparam int ACC_BITS    = 37;
	localparam int ADDR_BITS   = 3;
	localparam int DATA_BITS   = 32;
	localparam int NUM_LANES   = 2;

	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

	localparam logic REG_REGION_LEN  = 1'b0;
	localparam logic REG_NUM_COLUMNS = 1'b1;

	typedef struct packed {
		logic [REGION_BITS-1:0] region_len;
		logic [NCOL_BITS-1:0]   num_columns;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] column_peak;
		logic [INDEX_BITS-1:0]  column_index;
		logic                   last_column;
		logic                   config_error;
	} result_t;

endpackage

@@ design/wcp_channels.sv @@
interface wcp_sample_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [wcp_pkg::SAMPLE_BITS-1:0] left_sample;
	logic signed [wcp_pkg::SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, left_sample, right_sample, input ready);
	modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface wcp_peak_if;
	logic                              valid;
	logic                              ready;
	logic [wcp_pkg::SAMPLE_BITS-1:0]   column_peak;
	logic [wcp_pkg::INDEX_BITS-1:0]    column_index;
	logic                              last_column;
	logic                              config_error;

	modport source (output valid, column_peak, column_index, last_column, config_error,
		input ready);
	modport sink   (input valid, column_peak, column_index, last_column, config_error,
		output ready);
endinterface

@@ design/waveform_column_peak_core.sv @@
// The sample stage (valid_s1, mag_s1) registers an accepted pair, the column stage
// its result. One pair per cycle, and column end and peak update in the same cycle;
// a closing pair waits on a stalled result, and the sample stage holds behind it.
// Reset (arst_n low, asynchronous): region_len = 1, num_columns = 1, pass re-armed,
// pipeline empty. Any register write re-arms the pass on the following cycle.
module waveform_column_peak_core (
	input  logic                              clk,
	input  logic                              arst_n,
	wcp_sample_if.sink                        samples,
	wcp_peak_if.source                        peaks,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wcp_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [wcp_pkg::DATA_BITS-1:0]     pwdata,
	output logic [wcp_pkg::DATA_BITS-1:0]     prdata,
	output logic                              pready
);

	wcp_pkg::cfg_t                   cfg_q;
	logic                            rearm_q;
	logic                            cfg_wr;
	logic [wcp_pkg::SAMPLE_BITS-1:0] mag [wcp_pkg::NUM_LANES];
	logic [wcp_pkg::SAMPLE_BITS-1:0] mag_max;
	logic                            valid_s1;
	logic [wcp_pkg::SAMPLE_BITS-1:0] mag_s1;
	logic                            take;
	wcp_pkg::result_t                result;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_len  <= wcp_pkg::REGION_BITS'(1);
			cfg_q.num_columns <= wcp_pkg::NCOL_BITS'(1);
			rearm_q           <= 1'b0;
		end else begin
			rearm_q <= cfg_wr;
			if (cfg_wr) begin
				case (paddr[2])
					wcp_pkg::REG_REGION_LEN:  cfg_q.region_len  <= pwdata[wcp_pkg::REGION_BITS-1:0];
					wcp_pkg::REG_NUM_COLUMNS: cfg_q.num_columns <= pwdata[wcp_pkg::NCOL_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[2])
			wcp_pkg::REG_REGION_LEN:  prdata = wcp_pkg::DATA_BITS'(cfg_q.region_len);
			wcp_pkg::REG_NUM_COLUMNS: prdata = wcp_pkg::DATA_BITS'(cfg_q.num_columns);
			default:                  prdata = '0;
		endcase
	end

	wcp_lane u_lane_left (
		.sample    (samples.left_sample),
		.magnitude (mag[0])
	);

	wcp_lane u_lane_right (
		.sample    (samples.right_sample),
		.magnitude (mag[1])
	);

	assign mag_max = (mag[0] > mag[1]) ? mag[0] : mag[1];

	assign samples.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			mag_s1 <= mag_max;
		end
	end

	wcp_column u_column (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rearm     (rearm_q),
		.valid_s1  (valid_s1),
		.mag_s1    (mag_s1),
		.take      (take),
		.out_valid (peaks.valid),
		.out_ready (peaks.ready),
		.result    (result)
	);

	assign peaks.column_peak  = result.column_peak;
	assign peaks.column_index = result.column_index;
	assign peaks.last_column  = result.last_column;
	assign peaks.config_error = result.config_error;

endmodule

@@ design/wcp_lane.sv @@
module wcp_lane (
	input  logic signed [wcp_pkg::SAMPLE_BITS-1:0] sample,
	output logic        [wcp_pkg::SAMPLE_BITS-1:0] magnitude
);

	// most negative code maps to full scale
	assign magnitude = sample[wcp_pkg::SAMPLE_BITS-1]
		? wcp_pkg::SAMPLE_BITS'(~sample + 1'b1)
		: wcp_pkg::SAMPLE_BITS'(sample);

endmodule

@@ design/wcp_column.sv @@
module wcp_column (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wcp_pkg::cfg_t                   cfg,
	input  logic                            rearm,
	input  logic                            valid_s1,
	input  logic [wcp_pkg::SAMPLE_BITS-1:0] mag_s1,
	output logic                            take,
	output logic                            out_valid,
	input  logic                            out_ready,
	output wcp_pkg::result_t                result
);

	logic [wcp_pkg::SAMPLE_BITS-1:0] peak_q;
	logic [wcp_pkg::INDEX_BITS-1:0]  count_q;
	logic [wcp_pkg::ACC_BITS-1:0]    pos_q;
	logic [wcp_pkg::ACC_BITS-1:0]    end_q;
	logic                            out_valid_q;
	wcp_pkg::result_t                result_q;

	logic                            cfg_bad;
	logic                            boundary;
	logic                            produces;
	logic                            last;
	logic [wcp_pkg::SAMPLE_BITS-1:0] peak_max;
	logic [wcp_pkg::SAMPLE_BITS-1:0] peak_next;
	logic [wcp_pkg::ACC_BITS-1:0]    n_ext;
	logic [wcp_pkg::ACC_BITS-1:0]    ncol_ext;
	logic [wcp_pkg::ACC_BITS-1:0]    pos_init;

	assign n_ext    = wcp_pkg::ACC_BITS'(cfg.region_len);
	assign ncol_ext = wcp_pkg::ACC_BITS'(cfg.num_columns);
	assign pos_init = wcp_pkg::ACC_BITS'({cfg.num_columns, 1'b0});

	assign cfg_bad = (cfg.num_columns == '0)
		|| (cfg.num_columns > wcp_pkg::NCOL_BITS'(wcp_pkg::MAX_COLUMNS))
		|| (cfg.region_len < wcp_pkg::REGION_BITS'(cfg.num_columns));

	assign peak_max  = (mag_s1 > peak_q) ? mag_s1 : peak_q;
	assign peak_next = (peak_max > wcp_pkg::FULL_SCALE) ? wcp_pkg::FULL_SCALE : peak_max;
	assign boundary  = end_q < pos_q;
	assign last      = ({1'b0, count_q} + 1'b1) >= cfg.num_columns;
	assign produces  = cfg_bad || boundary;
	assign take      = valid_s1 && (!produces || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			count_q <= '0;
			pos_q   <= wcp_pkg::ACC_BITS'(2);
			end_q   <= wcp_pkg::ACC_BITS'(1);
		end else if (rearm) begin
			peak_q  <= '0;
			count_q <= '0;
			pos_q   <= pos_init;
			end_q   <= n_ext;
		end else if (take && !cfg_bad) begin
			if (boundary && last) begin
				peak_q  <= '0;
				count_q <= '0;
				pos_q   <= pos_init;
				end_q   <= n_ext;
			end else if (boundary) begin
				peak_q  <= '0;
				count_q <= count_q + 1'b1;
				pos_q   <= pos_q + ncol_ext;
				end_q   <= end_q + n_ext;
			end else begin
				peak_q <= peak_next;
				pos_q  <= pos_q + ncol_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && produces) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produces) begin
			if (cfg_bad) begin
				result_q <= '{column_peak: '0, column_index: '0, last_column: 1'b0,
					config_error: 1'b1};
			end else begin
				result_q <= '{column_peak: peak_next, column_index: count_q,
					last_column: last, config_error: 1'b0};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	a_peak_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q <= wcp_pkg::FULL_SCALE)
		else $error("running peak above full scale");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.config_error) |->
		(result_q.column_peak == '0 && result_q.column_index == '0 && !result_q.last_column))
		else $error("error beat carries payload");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(take && boundary && !cfg_bad && !rearm) |=>
		(result_q.last_column == (({1'b0, result_q.column_index} + 1'b1) >= cfg.num_columns)))
		else $error("last column flag disagrees with index");

	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(result_q)))
		else $error("pending beat dropped");

endmodule

@@ tb/tb_waveform_column_peak_core.sv @@
`timescale 1ns / 100ps

module tb_waveform_column_peak_core;
	import wcp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;

	typedef struct {
		logic [SAMPLE_BITS-1:0] left;
		logic [SAMPLE_BITS-1:0] right;
		int unsigned            gap;
	} sample_pair_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	wcp_sample_if samples_ch();
	wcp_peak_if   peaks_ch();

	waveform_column_peak_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.peaks   (peaks_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sample_pair_t pairs_to_send[$];
	result_t      peaks_due[$];
	int unsigned  pairs_queued = 0;
	int unsigned  pairs_taken  = 0;
	int unsigned  mismatches   = 0;
	int unsigned  send_idle    = 0;
	int unsigned  stall_left   = 0;
	int unsigned  hold_left    = 0;
	int unsigned  quiet        = 0;
	bit           tx_idle_on   = 1'b1;
	bit           rx_idle_on   = 1'b1;
	logic         hold_req     = 1'b0;

	// column peak tracker state
	logic [REGION_BITS-1:0] region_len;
	logic [NCOL_BITS-1:0]   num_columns;
	logic [SAMPLE_BITS-1:0] running_peak;
	logic [INDEX_BITS-1:0]  column_count;
	logic [ACC_BITS-1:0]    sample_pos;
	logic [ACC_BITS-1:0]    column_end;

	function automatic void rearm_pass();
		running_peak = '0;
		column_count = '0;
		sample_pos   = ACC_BITS'({num_columns, 1'b0});
		column_end   = ACC_BITS'(region_len);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
		return s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : s;
	endfunction

	function automatic bit step_column_peak(input logic [SAMPLE_BITS-1:0] l,
		input logic [SAMPLE_BITS-1:0] r, output result_t res);
		logic [SAMPLE_BITS-1:0] ml;
		logic [SAMPLE_BITS-1:0] mr;
		logic [SAMPLE_BITS-1:0] m;
		bit                     fin;
		res = '0;
		if (num_columns == 0 || num_columns > MAX_COLUMNS || region_len < num_columns) begin
			res.config_error = 1'b1;
			return 1'b1;
		end
		ml = magnitude(l);
		mr = magnitude(r);
		m = (ml > mr) ? ml : mr;
		if (m > running_peak)
			running_peak = m;
		if (running_peak > FULL_SCALE)
			running_peak = FULL_SCALE;
		if (column_end < sample_pos) begin
			fin = (({1'b0, column_count} + 13'd1) >= num_columns);
			res.column_peak  = running_peak;
			res.column_index = column_count;
			res.last_column  = fin;
			if (fin) begin
				rearm_pass();
			end else begin
				running_peak = '0;
				column_count = column_count + 1'b1;
				column_end   = column_end + ACC_BITS'(region_len);
				sample_pos   = sample_pos + ACC_BITS'(num_columns);
			end
			return 1'b1;
		end
		sample_pos = sample_pos + ACC_BITS'(num_columns);
		return 1'b0;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : drive_samples
		sample_pair_t pair;
		if (!arst_n) begin
			samples_ch.valid <= 1'b0;
			send_idle <= 0;
		end else if (!samples_ch.valid || samples_ch.ready) begin
			if (pairs_to_send.size() > 0 && pairs_to_send[0].gap <= send_idle) begin
				pair = pairs_to_send.pop_front();
				samples_ch.valid        <= 1'b1;
				samples_ch.left_sample  <= pair.left;
				samples_ch.right_sample <= pair.right;
				send_idle <= 0;
			end else begin
				samples_ch.valid <= 1'b0;
				send_idle <= send_idle + 1;
			end
		end
	end

	always @(posedge clk) begin : drive_ready
		int unsigned g;
		if (!arst_n) begin
			peaks_ch.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
			peaks_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			peaks_ch.ready <= 1'b0;
		end else if (peaks_ch.valid && peaks_ch.ready) begin
			g = rx_idle_on ? $urandom_range(0, 16) : 0;
			stall_left <= g;
			peaks_ch.ready <= (g == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			peaks_ch.ready <= 1'b0;
		end else begin
			peaks_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_peaks
		result_t due;
		result_t made;
		if (arst_n) begin
			if (peaks_ch.valid && peaks_ch.ready) begin
				if (peaks_due.size() == 0) begin
					$error("unexpected peak beat: column_index %0d", peaks_ch.column_index);
					mismatches = mismatches + 1;
				end else begin
					due = peaks_due.pop_front();
					if (peaks_ch.column_peak !== due.column_peak) begin
						$error("column_peak: expected %h, actual %h",
							due.column_peak, peaks_ch.column_peak);
						mismatches = mismatches + 1;
					end
					if (peaks_ch.column_index !== due.column_index) begin
						$error("column_index: expected %0d, actual %0d",
							due.column_index, peaks_ch.column_index);
						mismatches = mismatches + 1;
					end
					if (peaks_ch.last_column !== due.last_column) begin
						$error("last_column: expected %b, actual %b",
							due.last_column, peaks_ch.last_column);
						mismatches = mismatches + 1;
					end
					if (peaks_ch.config_error !== due.config_error) begin
						$error("config_error: expected %b, actual %b",
							due.config_error, peaks_ch.config_error);
						mismatches = mismatches + 1;
					end
				end
			end
			if (samples_ch.valid && samples_ch.ready) begin
				if (step_column_peak(samples_ch.left_sample, samples_ch.right_sample, made))
					peaks_due.push_back(made);
				pairs_taken = pairs_taken + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (samples_ch.valid && samples_ch.ready) ||
			(peaks_ch.valid && peaks_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic write_register(input logic reg_sel, input logic [DATA_BITS-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_REGION_LEN)
			region_len = value[REGION_BITS-1:0];
		else
			num_columns = value[NCOL_BITS-1:0];
		rearm_pass();
		repeat (3) @(posedge clk);
	endtask

	task automatic set_region(input logic [DATA_BITS-1:0] n, input logic [DATA_BITS-1:0] cols);
		if ($urandom_range(0, 1)) begin
			write_register(REG_REGION_LEN, n);
			write_register(REG_NUM_COLUMNS, cols);
		end else begin
			write_register(REG_NUM_COLUMNS, cols);
			write_register(REG_REGION_LEN, n);
		end
	endtask

	task automatic queue_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
		sample_pair_t p;
		p.left  = l;
		p.right = r;
		p.gap   = tx_idle_on ? $urandom_range(0, 16) : 0;
		pairs_to_send.push_back(p);
		pairs_queued = pairs_queued + 1;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] draw_sample();
		case ($urandom_range(0, 5))
			0, 1:    return SAMPLE_BITS'($urandom);
			2:       return SAMPLE_BITS'($urandom_range(0, 511)) - SAMPLE_BITS'(256);
			3:       return SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
			4:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			default: return SAMPLE_BITS'($urandom) >>> $urandom_range(0, SAMPLE_BITS - 1);
		endcase
	endfunction

	task automatic queue_random(input int unsigned count);
		repeat (count) queue_pair(draw_sample(), draw_sample());
	endtask

	task automatic settle();
		while (pairs_taken < pairs_queued || peaks_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		int unsigned n_cols;
		int unsigned n_region;
		int unsigned count;
		int unsigned random_sent;
		int unsigned phase;
		bit          bad_cfg;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_ch.valid = 1'b0;
		samples_ch.left_sample = '0;
		samples_ch.right_sample = '0;
		peaks_ch.ready = 1'b0;
		region_len = REGION_BITS'(1);
		num_columns = NCOL_BITS'(1);
		rearm_pass();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset setting: every pair closes a one-sample column
		queue_pair(24'h800000, 24'h000000);
		queue_pair(24'h000000, 24'h800000);
		queue_pair(24'h7FFFFF, 24'h000001);
		queue_pair(24'hFFFFFF, 24'h7FFFFF);
		queue_pair(24'h000000, 24'h000000);
		settle();

		// uneven column widths, upper data bits set
		write_register(REG_REGION_LEN, 32'hFF00_0007);
		write_register(REG_NUM_COLUMNS, 32'hABCD_0003);
		queue_pair(24'h000010, 24'hFFFFF0);
		queue_pair(24'h000020, 24'h000001);
		queue_pair(24'h800001, 24'h000000);
		queue_pair(24'h000000, 24'h7FFFFE);
		queue_pair(24'h000003, 24'hFFFFFD);
		queue_pair(24'h800000, 24'h800000);
		queue_pair(24'h000000, 24'h000001);
		queue_pair(24'h555555, 24'hAAAAAA);
		queue_pair(24'h123456, 24'hEDCBA9);
		queue_pair(24'h000000, 24'h000000);
		settle();

		// unsupported settings
		write_register(REG_REGION_LEN, 32'd2);
		queue_random(2);
		settle();
		write_register(REG_NUM_COLUMNS, 32'd0);
		queue_random(2);
		settle();
		set_region(32'd16777215, 32'd8191);
		queue_random(2);
		settle();

		// widest column count: one sample per column
		set_region(32'd4096, 32'd4096);
		queue_random(400);
		settle();

		// longest region: no column closes
		set_region(32'd16777215, 32'd4096);
		queue_random(100);
		settle();

		random_sent = 0;
		phase = 0;
		while (random_sent < 950) begin
			bad_cfg = ($urandom_range(0, 9) == 0);
			if (bad_cfg) begin
				case ($urandom_range(0, 2))
					0: begin
						n_cols = $urandom_range(2, 64);
						n_region = $urandom_range(0, n_cols - 1);
					end
					1: begin
						n_cols = 0;
						n_region = $urandom_range(1, 100);
					end
					default: begin
						n_cols = $urandom_range(MAX_COLUMNS + 1, 8191);
						n_region = $urandom_range(MAX_COLUMNS + 1, 16777215);
					end
				endcase
				count = $urandom_range(1, 20);
			end else begin
				n_cols = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 16);
				n_region = $urandom_range(n_cols, 80);
				count = n_region * $urandom_range(1, 2) + $urandom_range(0, n_region - 1);
			end
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				n_cols = 1;
				n_region = 1;
				count = 80;
				tx_idle_on = 1'b0;
			end
			set_region(n_region, n_cols);
			if (phase == 2) begin
				@(posedge clk);
				hold_req <= 1'b1;
			end
			queue_random(count);
			random_sent = random_sent + count;
			settle();
			phase = phase + 1;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
